/* design/gzip_header_parser_macros.svh */
// ----------------------------------------------------------------------------
// gzip header parser assertion macros
// Shared concurrent assertion forms for the parser checker.
// ----------------------------------------------------------------------------
`ifndef GZIP_HEADER_PARSER_MACROS_SVH
`define GZIP_HEADER_PARSER_MACROS_SVH

// same-cycle implication, masked during reset
`define GHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define GHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// property checked on the cycle after reset is applied
`define GHP_ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

/* design/ghp_pkg.sv */
// ----------------------------------------------------------------------------
// ghp_pkg
// Types and constants shared by the gzip header parser files.
// ----------------------------------------------------------------------------
package ghp_pkg;

  typedef enum logic [4:0] {
    PH_ID1     = 5'd0,
    PH_ID2     = 5'd1,
    PH_CM      = 5'd2,
    PH_FLG     = 5'd3,
    PH_MT0     = 5'd4,
    PH_MT1     = 5'd5,
    PH_MT2     = 5'd6,
    PH_MT3     = 5'd7,
    PH_XFL     = 5'd8,
    PH_OS      = 5'd9,
    PH_XLEN0   = 5'd10,
    PH_XLEN1   = 5'd11,
    PH_EXTRA   = 5'd12,
    PH_NAME    = 5'd13,
    PH_COMMENT = 5'd14,
    PH_HCRC0   = 5'd15,
    PH_HCRC1   = 5'd16,
    PH_DONE    = 5'd17
  } phase_t;

  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_DONE    = 2'd1,
    ST_INVALID = 2'd2,
    ST_PAYLOAD = 2'd3
  } status_t;

  localparam logic [7:0] MAGIC_ONE      = 8'h1f;
  localparam logic [7:0] MAGIC_TWO      = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'h08;

  // bit positions in pending_flags
  localparam int FLAG_HCRC    = 0;
  localparam int FLAG_EXTRA   = 1;
  localparam int FLAG_NAME    = 2;
  localparam int FLAG_COMMENT = 3;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  pending_flags;
    logic [15:0] extra_remaining;
    logic        error_seen;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:           PH_ID1,
    pending_flags:   4'd0,
    extra_remaining: 16'd0,
    error_seen:      1'b0
  };

  typedef struct packed {
    status_t    status;
    logic [7:0] payload_byte;
  } step_result_t;

endpackage

/* design/ghp_if.sv */
// ----------------------------------------------------------------------------
// ghp channel interfaces
// Valid/ready channels for stream bytes in and parse results out.
// ----------------------------------------------------------------------------
interface ghp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface ghp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] payload_byte;

  modport source (output valid, output status, output payload_byte, input ready);
  modport sink (input valid, input status, input payload_byte, output ready);
endinterface

/* design/ghp_step.sv */
// ----------------------------------------------------------------------------
// ghp_step
// One-byte parser update: next header state and the byte's result.
// ----------------------------------------------------------------------------
module ghp_step (
  input  ghp_pkg::parse_state_t cur,
  input  logic [7:0]            data_byte,
  input  logic                  restart,
  output ghp_pkg::parse_state_t nxt,
  output ghp_pkg::step_result_t res
);

  // skip header parts that take no byte; transitions only move forward
  function automatic ghp_pkg::parse_state_t settle(input ghp_pkg::parse_state_t s);
    ghp_pkg::parse_state_t t;
    t = s;
    if (t.phase == ghp_pkg::PH_XLEN0 && !t.pending_flags[ghp_pkg::FLAG_EXTRA]) begin
      t.phase = ghp_pkg::PH_NAME;
    end
    if (t.phase == ghp_pkg::PH_EXTRA && t.extra_remaining == 16'd0) begin
      t.pending_flags[ghp_pkg::FLAG_EXTRA] = 1'b0;
      t.phase = ghp_pkg::PH_NAME;
    end
    if (t.phase == ghp_pkg::PH_NAME && !t.pending_flags[ghp_pkg::FLAG_NAME]) begin
      t.phase = ghp_pkg::PH_COMMENT;
    end
    if (t.phase == ghp_pkg::PH_COMMENT && !t.pending_flags[ghp_pkg::FLAG_COMMENT]) begin
      t.phase = ghp_pkg::PH_HCRC0;
    end
    if (t.phase == ghp_pkg::PH_HCRC0 && !t.pending_flags[ghp_pkg::FLAG_HCRC]) begin
      t.phase = ghp_pkg::PH_DONE;
    end
    return t;
  endfunction

  ghp_pkg::parse_state_t base;
  ghp_pkg::parse_state_t work;
  logic                  bad;

  always_comb begin
    base             = restart ? ghp_pkg::STATE_RESET : cur;
    work             = base;
    bad              = 1'b0;
    res.status       = ghp_pkg::ST_HEADER;
    res.payload_byte = 8'd0;
    nxt              = base;

    if (base.error_seen) begin
      res.status = ghp_pkg::ST_INVALID;
    end else if (base.phase >= ghp_pkg::PH_DONE) begin
      res.status       = ghp_pkg::ST_PAYLOAD;
      res.payload_byte = data_byte;
    end else begin
      case (base.phase)
        ghp_pkg::PH_ID1: begin
          bad        = (data_byte != ghp_pkg::MAGIC_ONE);
          work.phase = ghp_pkg::PH_ID2;
        end
        ghp_pkg::PH_ID2: begin
          bad        = (data_byte != ghp_pkg::MAGIC_TWO);
          work.phase = ghp_pkg::PH_CM;
        end
        ghp_pkg::PH_CM: begin
          bad        = (data_byte != ghp_pkg::METHOD_DEFLATE);
          work.phase = ghp_pkg::PH_FLG;
        end
        ghp_pkg::PH_FLG: begin
          // drop FTEXT and the reserved top bits
          work.pending_flags = data_byte[4:1];
          work.phase         = ghp_pkg::PH_MT0;
        end
        ghp_pkg::PH_XLEN0: begin
          work.extra_remaining = {8'd0, data_byte};
          work.phase           = ghp_pkg::PH_XLEN1;
        end
        ghp_pkg::PH_XLEN1: begin
          work.extra_remaining = {data_byte, base.extra_remaining[7:0]};
          work.phase           = ghp_pkg::PH_EXTRA;
        end
        ghp_pkg::PH_EXTRA: begin
          work.extra_remaining = base.extra_remaining - 16'd1;
        end
        ghp_pkg::PH_NAME: begin
          if (data_byte == 8'd0) begin
            work.pending_flags[ghp_pkg::FLAG_NAME] = 1'b0;
            work.phase = ghp_pkg::PH_COMMENT;
          end
        end
        ghp_pkg::PH_COMMENT: begin
          if (data_byte == 8'd0) begin
            work.pending_flags[ghp_pkg::FLAG_COMMENT] = 1'b0;
            work.phase = ghp_pkg::PH_HCRC0;
          end
        end
        ghp_pkg::PH_HCRC0: begin
          work.phase = ghp_pkg::PH_HCRC1;
        end
        ghp_pkg::PH_HCRC1: begin
          work.pending_flags[ghp_pkg::FLAG_HCRC] = 1'b0;
          work.phase = ghp_pkg::PH_DONE;
        end
        default: begin
          // mtime, xfl and os bytes
          work.phase = ghp_pkg::phase_t'(base.phase + 5'd1);
        end
      endcase

      if (bad) begin
        work.error_seen = 1'b1;
        res.status      = ghp_pkg::ST_INVALID;
        nxt             = work;
      end else begin
        nxt        = settle(work);
        res.status = (nxt.phase == ghp_pkg::PH_DONE) ? ghp_pkg::ST_DONE
                                                     : ghp_pkg::ST_HEADER;
      end
    end
  end

endmodule

/* design/gzip_header_parser.sv */
// ----------------------------------------------------------------------------
// gzip_header_parser
// Byte-serial gzip member header parser with payload pass-through.
// ----------------------------------------------------------------------------
// One byte is taken per transaction and one result comes back for each, in
// order. The block sustains one byte per clock while result.ready is held: a
// byte is held in the input register while the combinational header state
// update in ghp_step produces its result into the output register, so each
// byte goes through the input register and its result through the output
// register. The output register and the input register together hold two
// transactions, so one more byte is taken while a result waits.
// Status 0 means still in the header, 1 the byte that ends the header, 2 an
// invalid stream (sticky until a byte with restart set), 3 a payload byte,
// echoed on payload_byte. The header CRC is skipped, not checked.
module gzip_header_parser (
  input  logic          clk,
  input  logic          rst,
  ghp_in_if.sink        stream,
  ghp_out_if.source     result
);

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  s1_restart;
  logic                  out_valid;
  ghp_pkg::step_result_t out_res;
  ghp_pkg::parse_state_t state;
  ghp_pkg::parse_state_t state_next;
  ghp_pkg::step_result_t res_next;
  logic                  out_free;
  logic                  s1_advance;

  assign out_free     = !out_valid || result.ready;
  assign s1_advance   = s1_valid && out_free;
  assign stream.ready = !s1_valid || out_free;

  ghp_step u_step (
    .cur       (state),
    .data_byte (s1_byte),
    .restart   (s1_restart),
    .nxt       (state_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= ghp_pkg::STATE_RESET;
    end else begin
      if (stream.ready) begin
        s1_valid <= stream.valid;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s1_byte    <= stream.data_byte;
      s1_restart <= stream.restart;
    end
    if (s1_advance) begin
      out_res <= res_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_res.status;
  assign result.payload_byte = out_res.payload_byte;

endmodule

/* design/ghp_checker.sv */
// ----------------------------------------------------------------------------
// ghp_checker
// Port-level assertions for the gzip header parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "gzip_header_parser_macros.svh"

module ghp_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] status,
  input logic [7:0] payload_byte
);

  `GHP_ASSERT_AFTER_RESET(a_no_result_after_reset, !result_valid, "result valid after reset")
  `GHP_ASSERT_NEXT(a_stall_holds, result_valid && !result_ready, result_valid && $stable(status) && $stable(payload_byte), "stalled result changed")
  `GHP_ASSERT_NOW(a_zero_unless_payload, result_valid && status != ghp_pkg::ST_PAYLOAD, payload_byte == 8'd0, "nonzero byte on non-payload result")

endmodule

bind gzip_header_parser ghp_checker u_ghp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .status       (result.status),
  .payload_byte (result.payload_byte)
);
